[src/ssh1_packet_deframer_core_defines.svh]
// ----------------------------------------------------------------------------
// SSH-1 packet deframer assertion macros
// Concurrent assertion wrappers, removable with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef SSH1_PACKET_DEFRAMER_CORE_DEFINES_SVH
`define SSH1_PACKET_DEFRAMER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

[src/ssh1df_pkg.sv]
// ----------------------------------------------------------------------------
// SSH-1 packet deframer package
// Status codes, field widths and the byte-wide CRC-32 update.
// ----------------------------------------------------------------------------
`default_nettype none

package ssh1df_pkg;

  localparam int LEN_W = 19;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_CRC = 2'd1;
  localparam logic [1:0] ST_LEN = 2'd2;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 19'd262144;

  // reflected CRC-32, one byte
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[src/ssh1_packet_deframer_core.sv]
// ----------------------------------------------------------------------------
// SSH-1 packet deframer core
// Splits an SSH-1 binary packet byte stream and checks its CRC-32.
// ----------------------------------------------------------------------------
// Takes one byte per cycle on the slave stream while s_tready is high: a
// 4-byte big-endian length, 8 - (length mod 8) padding bytes, the type byte,
// length - 5 body bytes and a 4-byte big-endian CRC-32 over padding, type
// and body. Type and body bytes come out on the master stream (tuser[0]
// marks the type byte); the last CRC byte yields a status-only transfer with
// tlast set. A length below 5 or above max_length, or a CRC mismatch, gives
// a tlast transfer with an error status, after which all input is dropped
// until reset. State and CRC update are done in a single pass per byte, and
// a two-entry output stage keeps s_tready high while one result waits.
`default_nettype none
`include "ssh1_packet_deframer_core_defines.svh"

module ssh1_packet_deframer_core
  import ssh1df_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [7:0]       s_tdata,   // rx_byte
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [7:0]            m_tdata,   // out_byte
  output logic                  m_tlast,   // last
  output logic [2:0]            m_tuser,   // is_type, status[1:0]
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [LEN_W-1:0] cfg_data   // max_length
);

  typedef enum logic [2:0] {
    PH_LEN  = 3'd0,
    PH_PAD  = 3'd1,
    PH_TYPE = 3'd2,
    PH_BODY = 3'd3,
    PH_CRC  = 3'd4
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [2:0] user;
  } res_t;

  phase_t           phase, phase_next;
  logic [31:0]      length_accum, length_accum_next;
  logic [LEN_W-1:0] bytes_left, bytes_left_next;
  logic [31:0]      crc_running, crc_running_next;
  logic [31:0]      crc_received, crc_received_next;
  logic             halted, halted_next;
  logic [LEN_W-1:0] max_length;

  res_t             out_reg, skid_reg, res;
  logic             out_valid, skid_valid, res_valid;

  logic             accept;
  logic [31:0]      crc_upd;
  logic [31:0]      len_new;
  logic [31:0]      crc_rx_new;
  logic [LEN_W-1:0] len_m5;
  logic [LEN_W-1:0] cnt_inc;

  assign s_tready  = !skid_valid;
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;

  assign m_tvalid = out_valid;
  assign m_tdata  = out_reg.data;
  assign m_tlast  = out_reg.last;
  assign m_tuser  = out_reg.user;

  assign crc_upd    = crc32_byte(crc_running, s_tdata);
  assign len_new    = {length_accum[23:0], s_tdata};
  assign crc_rx_new = {crc_received[23:0], s_tdata};
  assign len_m5     = length_accum[LEN_W-1:0] - LEN_W'(5);
  assign cnt_inc    = bytes_left + LEN_W'(1);

  always_comb begin
    phase_next        = phase;
    length_accum_next = length_accum;
    bytes_left_next   = bytes_left;
    crc_running_next  = crc_running;
    crc_received_next = crc_received;
    halted_next       = halted;
    res_valid         = 1'b0;
    res               = '{data: 8'd0, last: 1'b0, user: {ST_OK, 1'b0}};
    if (accept && !halted) begin
      case (phase)
        PH_PAD: begin
          crc_running_next = crc_upd;
          bytes_left_next  = bytes_left - LEN_W'(1);
          if (bytes_left == LEN_W'(1)) phase_next = PH_TYPE;
        end
        PH_TYPE: begin
          crc_running_next = crc_upd;
          if (len_m5 == '0) begin
            phase_next      = PH_CRC;
            bytes_left_next = LEN_W'(4);
          end else begin
            phase_next      = PH_BODY;
            bytes_left_next = len_m5;
          end
          res_valid = 1'b1;
          res       = '{data: s_tdata, last: 1'b0, user: {ST_OK, 1'b1}};
        end
        PH_BODY: begin
          crc_running_next = crc_upd;
          bytes_left_next  = bytes_left - LEN_W'(1);
          if (bytes_left == LEN_W'(1)) begin
            phase_next      = PH_CRC;
            bytes_left_next = LEN_W'(4);
          end
          res_valid = 1'b1;
          res       = '{data: s_tdata, last: 1'b0, user: {ST_OK, 1'b0}};
        end
        PH_CRC: begin
          crc_received_next = crc_rx_new;
          bytes_left_next   = bytes_left - LEN_W'(1);
          if (bytes_left == LEN_W'(1)) begin
            res_valid = 1'b1;
            if (~crc_running != crc_rx_new) begin
              halted_next = 1'b1;
              res = '{data: 8'd0, last: 1'b1, user: {ST_CRC, 1'b0}};
            end else begin
              phase_next        = PH_LEN;
              length_accum_next = '0;
              bytes_left_next   = '0;
              crc_running_next  = CRC_INIT;
              crc_received_next = '0;
              res = '{data: 8'd0, last: 1'b1, user: {ST_OK, 1'b0}};
            end
          end
        end
        default: begin
          length_accum_next = len_new;
          bytes_left_next   = cnt_inc;
          if (cnt_inc >= LEN_W'(4)) begin
            if (len_new < 32'd5 || len_new > {13'd0, max_length}) begin
              halted_next = 1'b1;
              res_valid   = 1'b1;
              res = '{data: 8'd0, last: 1'b1, user: {ST_LEN, 1'b0}};
            end else begin
              phase_next        = PH_PAD;
              bytes_left_next   = LEN_W'(8) - LEN_W'(len_new[2:0]);
              crc_running_next  = CRC_INIT;
              crc_received_next = '0;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_LEN;
      length_accum <= '0;
      bytes_left   <= '0;
      crc_running  <= CRC_INIT;
      crc_received <= '0;
      halted       <= 1'b0;
      max_length   <= MAX_LEN_RESET;
      out_valid    <= 1'b0;
      skid_valid   <= 1'b0;
    end else begin
      phase        <= phase_next;
      length_accum <= length_accum_next;
      bytes_left   <= bytes_left_next;
      crc_running  <= crc_running_next;
      crc_received <= crc_received_next;
      halted       <= halted_next;
      if (cfg_valid && cfg_ready) max_length <= cfg_data;
      if (out_valid && m_tready) begin
        if (skid_valid) begin
          out_reg    <= skid_reg;
          skid_valid <= 1'b0;
        end else if (res_valid) begin
          out_reg <= res;
        end else begin
          out_valid <= 1'b0;
        end
      end else if (res_valid) begin
        if (out_valid) begin
          skid_reg   <= res;
          skid_valid <= 1'b1;
        end else begin
          out_reg   <= res;
          out_valid <= 1'b1;
        end
      end
    end
  end

  `ASSERT_ALWAYS(a_skid_needs_out, skid_valid |-> out_valid, "skid full with output empty")
  `ASSERT_CLK(a_halt_sticks, halted |=> halted, "halt released without reset")
  `ASSERT_CLK(a_status_only_zero, (m_tvalid && m_tlast) |-> (m_tdata == 8'd0 && !m_tuser[0]),
              "status transfer carries data")
  `ASSERT_CLK(a_no_res_halted, (halted && accept) |-> !res_valid, "result while halted")

endmodule

`default_nettype wire
